// ===== rtl/masked_mult_mod_q_defines.svh =====
// Assertion macros for the masked modular multiplier.
// Used by the top level only; no other dependencies.
`ifndef MASKED_MULT_MOD_Q_DEFINES_SVH
`define MASKED_MULT_MOD_Q_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MMQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("masked_mult_mod_q: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define MMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("masked_mult_mod_q: next-cycle check failed");

`endif

// ===== rtl/mmq_pkg.sv =====
// Shared constants, types and helpers for the masked modular multiplier.
// No dependencies; the interfaces, multiplier, top level and testbench refer to it by scoped names.
package mmq_pkg;

    localparam int ORDER   = 2;
    localparam int NSHARES = ORDER + 1;
    localparam int SIDX_W  = (NSHARES > 1) ? $clog2(NSHARES) : 1;
    localparam int CNT_W   = $clog2(NSHARES + 1);

    localparam int VAL_W   = 14;
    localparam int WORD_W  = 16;
    localparam int IDX_W   = 3;
    localparam int ROW_W   = 3 * VAL_W;
    localparam int PROD_W  = WORD_W + VAL_W;
    localparam int RED_W   = VAL_W + 1;

    // Barrett reduction: quotient estimate is (p * BAR_M) >> BAR_K, off by at most one.
    localparam int BAR_K   = PROD_W;
    localparam int QEST_W  = 17;
    localparam int TPROD_W = PROD_W + QEST_W;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [SIDX_W-1:0] t_sidx;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [QEST_W-1:0] t_qest;

    localparam t_val  Q_MOD    = 14'd12289;
    localparam t_qest BAR_M    = 17'd87374;
    // The modulus is 2^13 + 2^12 + 1, so a multiple of it is a shift-add.
    localparam int    Q_SH_HI  = 13;
    localparam int    Q_SH_LO  = 12;
    localparam t_val  VAL_ONE  = 14'd1;

    localparam t_cnt  CNT_FULL  = t_cnt'(NSHARES);
    localparam t_cnt  CNT_ORDER = t_cnt'(ORDER);
    localparam t_cnt  CNT_LAST_LO = t_cnt'(ORDER - 1);
    localparam t_cnt  CNT_ONE   = t_cnt'(1);
    localparam t_cnt  CNT_TWO   = t_cnt'(2);

    // Row layout in the share store: {a, b, z}.
    localparam int ROW_A_HI = ROW_W - 1;
    localparam int ROW_B_HI = 2 * VAL_W - 1;
    localparam int ROW_Z_HI = VAL_W - 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_A,
        ST_LD_B,
        ST_LD_AB,
        ST_RND,
        ST_RD_I,
        ST_RD_J,
        ST_CAP_J,
        ST_MUL_IJ,
        ST_MUL_JI,
        ST_WR_J,
        ST_WR_I,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic  start;
        t_word x;
        t_val  y;
    } t_mul_req;

    typedef struct packed {
        logic done;
        t_val res;
    } t_mul_rsp;

    // Modular add of x < Q and y <= Q.
    function automatic t_val add_mod(input t_val x, input t_val y);
        logic [RED_W-1:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, Q_MOD}) begin
            s = s - {1'b0, Q_MOD};
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

// ===== rtl/mmq_if.sv =====
// Valid/ready channel interfaces for input and result beats.
// Depends on mmq_pkg for the payload widths.
interface mmq_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    mmq_pkg::t_val        a_share;
    mmq_pkg::t_val        b_share;
    mmq_pkg::t_word       random_word;

    modport source (output valid, output action, output a_share, output b_share,
                    output random_word, input ready);
    modport sink   (input valid, input action, input a_share, input b_share,
                    input random_word, output ready);
endinterface

interface mmq_out_if;
    logic                        valid;
    logic                        ready;
    logic [mmq_pkg::IDX_W-1:0]   share_index;
    mmq_pkg::t_val               share_value;
    logic                        last;

    modport source (output valid, output share_index, output share_value, output last,
                    input ready);
    modport sink   (input valid, input share_index, input share_value, input last,
                    output ready);
endinterface

// ===== rtl/mmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mmq_mulmod.sv =====
// Four-stage modular multiplier (x * y mod 12289) using Barrett reduction.
// Depends on mmq_pkg for widths, constants and the request/response structs.
module mmq_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmq_pkg::t_mul_req i_req,
    output mmq_pkg::t_mul_rsp o_rsp
);

    logic [3:0]                          r_vld;
    logic [mmq_pkg::PROD_W-1:0]          r_p1;
    logic [mmq_pkg::PROD_W-1:0]          r_p2;
    logic [mmq_pkg::TPROD_W-1:0]         r_t;
    logic [mmq_pkg::RED_W-1:0]           r_red;
    mmq_pkg::t_val                       r_res;

    mmq_pkg::t_qest                      w_qest;
    logic [mmq_pkg::RED_W-1:0]           w_qq;
    logic [mmq_pkg::RED_W-1:0]           w_red;

    // Only the low bits of p - qest*Q matter, since the true value is below 2Q.
    assign w_qest = r_t[mmq_pkg::BAR_K +: mmq_pkg::QEST_W];
    assign w_qq   = mmq_pkg::RED_W'(w_qest << mmq_pkg::Q_SH_HI)
                  + mmq_pkg::RED_W'(w_qest << mmq_pkg::Q_SH_LO)
                  + mmq_pkg::RED_W'(w_qest);
    assign w_red  = r_p2[mmq_pkg::RED_W-1:0] - w_qq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_req.start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1  <= mmq_pkg::PROD_W'(i_req.x) * mmq_pkg::PROD_W'(i_req.y);
        r_p2  <= r_p1;
        r_t   <= mmq_pkg::TPROD_W'(r_p1) * mmq_pkg::TPROD_W'(mmq_pkg::BAR_M);
        r_red <= w_red;
        if (r_red >= {1'b0, mmq_pkg::Q_MOD}) begin
            r_res <= mmq_pkg::VAL_W'(r_red - {1'b0, mmq_pkg::Q_MOD});
        end else begin
            r_res <= r_red[mmq_pkg::VAL_W-1:0];
        end
    end

    assign o_rsp.done = r_vld[3];
    assign o_rsp.res  = r_res;

endmodule

// ===== rtl/masked_mult_mod_q.sv =====
// Masked (ISW) multiplier of two arithmetically shared values mod 12289.
// Load beat: three passes through the 4-stage modular multiplier.
// Random-word beat: three multiplier passes, two store reads and two writes.
// After the final random word the shares go out one at a time, each held until taken.
// Ignored beats are accepted in idle and change nothing. Synchronous active-low reset clears the
// counters (r_hi starts at one); the share store is undefined until loaded.
`include "masked_mult_mod_q_defines.svh"

module masked_mult_mod_q (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmq_in_if.sink     i_in,
    mmq_out_if.source  o_out
);

    mmq_pkg::t_state   r_state, n_state;
    logic              r_issued, n_issued;
    mmq_pkg::t_cnt     r_loaded, n_loaded;
    mmq_pkg::t_cnt     r_lo, n_lo;
    mmq_pkg::t_cnt     r_hi, n_hi;
    mmq_pkg::t_cnt     r_k, n_k;
    logic              r_out_valid, n_out_valid;

    logic [mmq_pkg::IDX_W-1:0] r_out_idx, n_out_idx;
    mmq_pkg::t_val     r_out_val, n_out_val;
    logic              r_out_last, n_out_last;
    mmq_pkg::t_val     r_a_in, r_b_in;
    mmq_pkg::t_word    r_w;
    mmq_pkg::t_val     r_a_red, n_a_red;
    mmq_pkg::t_val     r_b_red, n_b_red;
    mmq_pkg::t_val     r_r, n_r;
    mmq_pkg::t_val     r_acc, n_acc;
    mmq_pkg::t_row     r_row_i, n_row_i;
    mmq_pkg::t_row     r_row_j, n_row_j;

    logic              w_in_acc;
    logic              w_in_mul;
    logic              w_out_fin;
    mmq_pkg::t_mul_req w_req;
    mmq_pkg::t_mul_rsp w_rsp;
    logic              w_we;
    mmq_pkg::t_sidx    w_waddr;
    mmq_pkg::t_row     w_wdata;
    mmq_pkg::t_sidx    w_raddr;
    mmq_pkg::t_row     w_rdata;

    mmq_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    mmq_ram #(
        .WIDTH (mmq_pkg::ROW_W),
        .DEPTH (mmq_pkg::NSHARES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in.ready        = (r_state == mmq_pkg::ST_IDLE);
    assign w_in_acc          = i_in.valid && i_in.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.share_index = r_out_idx;
    assign o_out.share_value = r_out_val;
    assign o_out.last        = r_out_last;
    assign w_out_fin         = o_out.valid && o_out.ready && o_out.last;

    assign w_in_mul = (r_state == mmq_pkg::ST_LD_A)   || (r_state == mmq_pkg::ST_LD_B)  ||
                      (r_state == mmq_pkg::ST_LD_AB)  || (r_state == mmq_pkg::ST_RND)   ||
                      (r_state == mmq_pkg::ST_MUL_IJ) || (r_state == mmq_pkg::ST_MUL_JI);

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_loaded    = r_loaded;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        n_a_red     = r_a_red;
        n_b_red     = r_b_red;
        n_r         = r_r;
        n_acc       = r_acc;
        n_row_i     = r_row_i;
        n_row_j     = r_row_j;

        w_req.start = w_in_mul && !r_issued;
        w_req.x     = '0;
        w_req.y     = mmq_pkg::VAL_ONE;
        w_we        = 1'b0;
        w_waddr     = r_lo[mmq_pkg::SIDX_W-1:0];
        w_wdata     = r_row_i;
        w_raddr     = r_lo[mmq_pkg::SIDX_W-1:0];

        // One multiplier pass per state: issue once, then wait for the result.
        if (w_req.start) begin
            n_issued = 1'b1;
        end else if (w_rsp.done) begin
            n_issued = 1'b0;
        end

        unique case (r_state)
            mmq_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (!i_in.action) begin
                        if (r_loaded < mmq_pkg::CNT_FULL) begin
                            n_state = mmq_pkg::ST_LD_A;
                        end
                    end else if (r_loaded == mmq_pkg::CNT_FULL) begin
                        n_state = mmq_pkg::ST_RND;
                    end
                end
            end
            mmq_pkg::ST_LD_A: begin
                w_req.x = mmq_pkg::t_word'(r_a_in);
                if (w_rsp.done) begin
                    n_a_red = w_rsp.res;
                    n_state = mmq_pkg::ST_LD_B;
                end
            end
            mmq_pkg::ST_LD_B: begin
                w_req.x = mmq_pkg::t_word'(r_b_in);
                if (w_rsp.done) begin
                    n_b_red = w_rsp.res;
                    n_state = mmq_pkg::ST_LD_AB;
                end
            end
            mmq_pkg::ST_LD_AB: begin
                w_req.x = mmq_pkg::t_word'(r_a_red);
                w_req.y = r_b_red;
                w_waddr = r_loaded[mmq_pkg::SIDX_W-1:0];
                w_wdata = {r_a_red, r_b_red, w_rsp.res};
                if (w_rsp.done) begin
                    w_we     = 1'b1;
                    n_loaded = r_loaded + mmq_pkg::CNT_ONE;
                    n_state  = mmq_pkg::ST_IDLE;
                end
            end
            mmq_pkg::ST_RND: begin
                w_req.x = r_w;
                if (w_rsp.done) begin
                    n_r     = w_rsp.res;
                    n_state = mmq_pkg::ST_RD_I;
                end
            end
            mmq_pkg::ST_RD_I: begin
                w_raddr = r_lo[mmq_pkg::SIDX_W-1:0];
                n_state = mmq_pkg::ST_RD_J;
            end
            mmq_pkg::ST_RD_J: begin
                w_raddr = r_hi[mmq_pkg::SIDX_W-1:0];
                n_row_i = w_rdata;
                n_state = mmq_pkg::ST_CAP_J;
            end
            mmq_pkg::ST_CAP_J: begin
                n_row_j = w_rdata;
                n_acc   = mmq_pkg::add_mod(w_rdata[mmq_pkg::ROW_Z_HI:0], r_r);
                n_state = mmq_pkg::ST_MUL_IJ;
            end
            mmq_pkg::ST_MUL_IJ: begin
                w_req.x = mmq_pkg::t_word'(r_row_i[mmq_pkg::ROW_A_HI -: mmq_pkg::VAL_W]);
                w_req.y = r_row_j[mmq_pkg::ROW_B_HI -: mmq_pkg::VAL_W];
                if (w_rsp.done) begin
                    n_acc   = mmq_pkg::add_mod(r_acc, w_rsp.res);
                    n_state = mmq_pkg::ST_MUL_JI;
                end
            end
            mmq_pkg::ST_MUL_JI: begin
                w_req.x = mmq_pkg::t_word'(r_row_j[mmq_pkg::ROW_A_HI -: mmq_pkg::VAL_W]);
                w_req.y = r_row_i[mmq_pkg::ROW_B_HI -: mmq_pkg::VAL_W];
                if (w_rsp.done) begin
                    n_acc   = mmq_pkg::add_mod(r_acc, w_rsp.res);
                    n_state = mmq_pkg::ST_WR_J;
                end
            end
            mmq_pkg::ST_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_hi[mmq_pkg::SIDX_W-1:0];
                w_wdata = {r_row_j[mmq_pkg::ROW_A_HI:mmq_pkg::VAL_W], r_acc};
                n_state = mmq_pkg::ST_WR_I;
            end
            mmq_pkg::ST_WR_I: begin
                w_we    = 1'b1;
                w_waddr = r_lo[mmq_pkg::SIDX_W-1:0];
                w_wdata = {r_row_i[mmq_pkg::ROW_A_HI:mmq_pkg::VAL_W],
                           mmq_pkg::add_mod(r_row_i[mmq_pkg::ROW_Z_HI:0],
                                            mmq_pkg::Q_MOD - r_r)};
                if ((r_hi == mmq_pkg::CNT_ORDER) && (r_lo == mmq_pkg::CNT_LAST_LO)) begin
                    n_k     = '0;
                    n_state = mmq_pkg::ST_OUT_RD;
                end else if (r_hi == mmq_pkg::CNT_ORDER) begin
                    n_lo    = r_lo + mmq_pkg::CNT_ONE;
                    n_hi    = r_lo + mmq_pkg::CNT_TWO;
                    n_state = mmq_pkg::ST_IDLE;
                end else begin
                    n_hi    = r_hi + mmq_pkg::CNT_ONE;
                    n_state = mmq_pkg::ST_IDLE;
                end
            end
            mmq_pkg::ST_OUT_RD: begin
                w_raddr = r_k[mmq_pkg::SIDX_W-1:0];
                n_state = mmq_pkg::ST_OUT_CAP;
            end
            mmq_pkg::ST_OUT_CAP: begin
                n_out_valid = 1'b1;
                n_out_idx   = mmq_pkg::IDX_W'(r_k);
                n_out_val   = w_rdata[mmq_pkg::ROW_Z_HI:0];
                n_out_last  = (r_k == mmq_pkg::CNT_ORDER);
                n_state     = mmq_pkg::ST_OUT_WAIT;
            end
            mmq_pkg::ST_OUT_WAIT: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_k == mmq_pkg::CNT_ORDER) begin
                        n_loaded = '0;
                        n_lo     = '0;
                        n_hi     = mmq_pkg::CNT_ONE;
                        n_state  = mmq_pkg::ST_IDLE;
                    end else begin
                        n_k      = r_k + mmq_pkg::CNT_ONE;
                        n_state  = mmq_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = mmq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmq_pkg::ST_IDLE;
            r_issued    <= 1'b0;
            r_loaded    <= '0;
            r_lo        <= '0;
            r_hi        <= mmq_pkg::CNT_ONE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_loaded    <= n_loaded;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_in <= i_in.a_share;
            r_b_in <= i_in.b_share;
            r_w    <= i_in.random_word;
        end
        r_out_idx  <= n_out_idx;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
        r_a_red    <= n_a_red;
        r_b_red    <= n_b_red;
        r_r        <= n_r;
        r_acc      <= n_acc;
        r_row_i    <= n_row_i;
        r_row_j    <= n_row_j;
    end

    `MMQ_ASSERT_SAME(a_busy_while_out, i_clk, i_rst_n, r_out_valid, !i_in.ready)
    `MMQ_ASSERT_SAME(a_done_when_issued, i_clk, i_rst_n, w_rsp.done, r_issued && w_in_mul)
    `MMQ_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_loaded <= mmq_pkg::CNT_FULL)
    `MMQ_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_out_fin, r_loaded == '0)

endmodule

// ===== tb/masked_mult_mod_q_tb.sv =====
// Testbench for the masked modular multiplier: share loads, random words and ignored beats
// are checked against an in-bench predictor of the output shares.
// Depends on mmq_pkg, the channel interfaces in mmq_if.sv and the masked_mult_mod_q RTL.
module masked_mult_mod_q_tb;

    localparam int          ORD       = mmq_pkg::ORDER;
    localparam int          NSH       = mmq_pkg::NSHARES;
    localparam int          NPAIRS    = NSH * ORD / 2;
    localparam int unsigned Q         = 12289;
    localparam int          HOLD_LEN  = 400;
    localparam int          SETTLE    = 40;
    localparam bit          ACT_LOAD  = 1'b0;
    localparam bit          ACT_WORD  = 1'b1;

    typedef struct packed {
        logic [mmq_pkg::IDX_W-1:0] index;
        mmq_pkg::t_val             value;
        logic                      last;
    } t_share_beat;

    logic clk = 1'b0;
    logic rst_n;

    mmq_in_if  in_if ();
    mmq_out_if out_if ();

    masked_mult_mod_q dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: the loaded shares, the running output shares and the pair pointer.
    int unsigned a_held [NSH];
    int unsigned b_held [NSH];
    int unsigned z_acc  [NSH];
    int          loaded_pairs;
    int          pair_lo;
    int          pair_hi;

    t_share_beat expected_shares [$];

    int  errors;
    int  used_beats;
    int  ignored_beats;
    int  groups_done;
    int  shares_checked;
    bit  src_gaps;
    bit  sink_stalls;
    int  hold_left;

    function automatic int unsigned mul_mod_q(input int unsigned x, input int unsigned y);
        return (x * y) % Q;
    endfunction

    // Applies one accepted beat to the predictor; returns 1 if the block acts on it.
    function automatic bit apply_beat(input bit action, input mmq_pkg::t_val a,
                                      input mmq_pkg::t_val b, input mmq_pkg::t_word w);
        int unsigned r;
        t_share_beat beat;
        if (action == ACT_LOAD) begin
            if (loaded_pairs >= NSH) return 1'b0;
            a_held[loaded_pairs] = a % Q;
            b_held[loaded_pairs] = b % Q;
            z_acc[loaded_pairs]  = mul_mod_q(a_held[loaded_pairs], b_held[loaded_pairs]);
            loaded_pairs++;
            return 1'b1;
        end
        if (loaded_pairs != NSH) return 1'b0;
        r = w % Q;
        z_acc[pair_lo] = (z_acc[pair_lo] + Q - r) % Q;
        z_acc[pair_hi] = (z_acc[pair_hi] + r
                          + mul_mod_q(a_held[pair_lo], b_held[pair_hi])
                          + mul_mod_q(a_held[pair_hi], b_held[pair_lo])) % Q;
        pair_hi++;
        if (pair_hi > ORD) begin
            pair_lo++;
            pair_hi = pair_lo + 1;
        end
        if (pair_lo < ORD) return 1'b1;
        for (int k = 0; k < NSH; k++) begin
            beat.index = mmq_pkg::IDX_W'(k);
            beat.value = mmq_pkg::t_val'(z_acc[k]);
            beat.last  = (k == ORD);
            expected_shares.push_back(beat);
        end
        loaded_pairs = 0;
        pair_lo      = 0;
        pair_hi      = 1;
        groups_done++;
        return 1'b1;
    endfunction

    function automatic mmq_pkg::t_val rand_share();
        // Now and then a share that is not yet reduced below the modulus.
        if ($urandom_range(0, 7) == 0) return mmq_pkg::t_val'($urandom_range(12289, 16383));
        return mmq_pkg::t_val'($urandom_range(0, 12288));
    endfunction

    task automatic send_beat(input bit action, input mmq_pkg::t_val a, input mmq_pkg::t_val b,
                             input mmq_pkg::t_word w);
        int gap;
        gap = 0;
        if (src_gaps && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.action      <= action;
        in_if.a_share     <= a;
        in_if.b_share     <= b;
        in_if.random_word <= w;
        do @(posedge clk); while (!in_if.ready);
        if (apply_beat(action, a, b, w)) used_beats++;
        else ignored_beats++;
    endtask

    task automatic send_load(input mmq_pkg::t_val a, input mmq_pkg::t_val b);
        send_beat(ACT_LOAD, a, b, mmq_pkg::t_word'($urandom_range(0, 65535)));
    endtask

    task automatic send_word(input mmq_pkg::t_word w);
        send_beat(ACT_WORD, mmq_pkg::t_val'($urandom_range(0, 16383)),
                  mmq_pkg::t_val'($urandom_range(0, 16383)), w);
    endtask

    // Drops valid and waits until every predicted share has been seen.
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (expected_shares.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_random_group(input int noise_pct);
        for (int k = 0; k < NSH; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_word(mmq_pkg::t_word'($urandom_range(0, 65535)));
            end
            send_load(rand_share(), rand_share());
        end
        for (int k = 0; k < NPAIRS; k++) begin
            if ($urandom_range(0, 99) < noise_pct) send_load(rand_share(), rand_share());
            send_word(mmq_pkg::t_word'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_extremes();
        send_load(14'd0, 14'd0);
        send_load(14'd12288, 14'd12288);
        send_load(14'd0, 14'd12288);
        send_word(16'd0);
        send_word(16'd65535);
        send_word(16'd12288);
        // Shares at or above the modulus are reduced on load.
        send_load(14'd16383, 14'd12289);
        send_load(14'd12289, 14'd16383);
        send_load(14'd16383, 14'd16383);
        send_word(16'd12289);
        send_word(16'd36866);
        send_word(16'd65535);
        drain();
    endtask

    task automatic test_ignored_beats();
        // A random word before any share is loaded, and a load once all are loaded.
        send_word(16'd4321);
        for (int k = 0; k < NSH; k++) send_load(rand_share(), rand_share());
        send_load(14'd777, 14'd888);
        for (int k = 0; k < NPAIRS; k++) send_word(mmq_pkg::t_word'($urandom_range(0, 65535)));
        drain();
    endtask

    task automatic test_backpressure();
        src_gaps  = 1'b0;
        hold_left = HOLD_LEN;
        repeat (3) run_random_group(0);
        drain();
    endtask

    task automatic test_random_traffic();
        int target;
        target      = used_beats + 150;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        while (used_beats < target) run_random_group(10);
        drain();
    endtask

    task automatic test_steady_stream();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        repeat (8) run_random_group(0);
        drain();
    endtask

    // Receiver: random stall bursts, plus one long hold requested by the backpressure test.
    initial begin
        int stall_left;
        stall_left   = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge clk) begin
        t_share_beat want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_shares.size() == 0) begin
                $display("%0t: extra share, expected none, got index %0d value %0d last %0d",
                         $time, out_if.share_index, out_if.share_value, out_if.last);
                errors++;
            end else begin
                want = expected_shares.pop_front();
                shares_checked++;
                if (out_if.share_index !== want.index) begin
                    $display("%0t: share_index mismatch, expected %0d, got %0d",
                             $time, want.index, out_if.share_index);
                    errors++;
                end
                if (out_if.share_value !== want.value) begin
                    $display("%0t: share_value mismatch at index %0d, expected %0d, got %0d",
                             $time, want.index, want.value, out_if.share_value);
                    errors++;
                end
                if (out_if.last !== want.last) begin
                    $display("%0t: last mismatch at index %0d, expected %0d, got %0d",
                             $time, want.index, want.last, out_if.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        errors            = 0;
        used_beats        = 0;
        ignored_beats     = 0;
        groups_done       = 0;
        shares_checked    = 0;
        src_gaps          = 1'b0;
        sink_stalls       = 1'b0;
        hold_left         = 0;
        loaded_pairs      = 0;
        pair_lo           = 0;
        pair_hi           = 1;
        rst_n             <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.action      <= ACT_LOAD;
        in_if.a_share     <= '0;
        in_if.b_share     <= '0;
        in_if.random_word <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_ignored_beats();
        test_backpressure();
        test_random_traffic();
        test_steady_stream();

        $display("Ran %0d complete share groups from %0d accepted and %0d ignored beats.",
                 groups_done, used_beats, ignored_beats);
        $display("Checked %0d output shares, with random stalls and a %0d-cycle receiver hold.",
                 shares_checked, HOLD_LEN);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
